>>> sv/ilir_pkg.sv
package ilir_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_VALUE_W     = 64;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_OVERWRITE = 3'd3,
    CMD_READ      = 3'd4,
    CMD_READ_LAST = 3'd5,
    CMD_CLEAR     = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // per-cycle action broadcast to every cell
  typedef struct packed {
    logic wr_at;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage

>>> sv/ilir_if.sv
interface ilir_req_if;
  logic                         valid;
  logic                         ready;
  logic [ilir_pkg::CMD_W-1:0]   command;
  logic [ilir_pkg::POS_W-1:0]   position;
  logic [ilir_pkg::DATA_W-1:0]  item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface ilir_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ilir_pkg::DATA_W-1:0]    read_value;
  logic                           value_valid;
  logic [ilir_pkg::COUNT_W-1:0]   entry_count;
  logic [ilir_pkg::STATUS_W-1:0]  status;

  modport source (output valid, read_value, value_valid, entry_count, status, input ready);
  modport sink   (input valid, read_value, value_valid, entry_count, status, output ready);
endinterface

>>> sv/indexed_list_insert_remove.sv
// a result is registered and appears in the cycle after its request is accepted
// throughput: one command per cycle for every command while results drain, insert
//   and remove included; all cells shift in parallel in the cycle it is accepted
// the result register frees req.ready whenever it is empty or being drained
// reset clears the entry count and the result valid; cell contents are left as is
module indexed_list_insert_remove #(
  parameter int CAPACITY    = ilir_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ilir_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ilir_req_if.sink   req,
  ilir_rsp_if.source rsp
);

  // count needs to hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // index compare width: wide enough for both the position field and the count
  localparam int SEL_W = (CNT_W > ilir_pkg::POS_W) ? CNT_W : ilir_pkg::POS_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [SEL_W-1:0] pos_x;
  logic [SEL_W-1:0] cnt_x;
  logic [SEL_W-1:0] sel;
  logic [SEL_W-1:0] rd_sel;
  logic             full;
  logic             accept;
  logic             rd_hit;

  ilir_pkg::cell_ctl_t ctl;
  ilir_pkg::cell_ctl_t ctl_eff;
  ilir_pkg::status_t   status_next;

  logic [ilir_pkg::MAX_VALUE_W-1:0] item_wide;
  logic [ilir_pkg::MAX_VALUE_W-1:0] rd_wide;
  logic [VALUE_WIDTH-1:0]           new_value;
  logic [VALUE_WIDTH-1:0]           rd_data;
  logic [VALUE_WIDTH-1:0]           cell_value [CAPACITY];

  // request side is free when the result register is empty or drains this cycle
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign pos_x = SEL_W'(req.position);
  assign cnt_x = SEL_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));

  // handles are masked to the stored width
  assign item_wide = ilir_pkg::MAX_VALUE_W'(req.item_value);
  assign new_value = item_wide[VALUE_WIDTH-1:0];

  // command decode: picks the cell action, new count, status and read index
  always_comb begin
    ctl         = '0;
    sel         = pos_x;
    rd_sel      = pos_x;
    rd_hit      = 1'b0;
    count_next  = count;
    status_next = ilir_pkg::ST_OK;
    unique case (req.command)
      ilir_pkg::CMD_APPEND: begin
        if (full) begin
          status_next = ilir_pkg::ST_FULL;
        end else begin
          ctl.wr_at  = 1'b1;
          sel        = cnt_x;
          count_next = count + CNT_W'(1);
        end
      end
      ilir_pkg::CMD_INSERT: begin
        // index check wins over the full check
        if (pos_x > cnt_x) begin
          status_next = ilir_pkg::ST_BAD_INDEX;
        end else if (full) begin
          status_next = ilir_pkg::ST_FULL;
        end else begin
          ctl.wr_at    = 1'b1;
          ctl.shift_up = 1'b1;
          count_next   = count + CNT_W'(1);
        end
      end
      ilir_pkg::CMD_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_next = ilir_pkg::ST_BAD_INDEX;
        end else begin
          ctl.shift_down = 1'b1;
          count_next     = count - CNT_W'(1);
        end
      end
      ilir_pkg::CMD_OVERWRITE: begin
        if (pos_x >= cnt_x) begin
          status_next = ilir_pkg::ST_BAD_INDEX;
        end else begin
          ctl.wr_at = 1'b1;
        end
      end
      ilir_pkg::CMD_READ: begin
        rd_hit = (pos_x < cnt_x);
      end
      ilir_pkg::CMD_READ_LAST: begin
        rd_hit = (count != '0);
        rd_sel = cnt_x - SEL_W'(1);
      end
      ilir_pkg::CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // unused code: list untouched
      end
    endcase
  end

  // cells only move on an accepted transaction
  assign ctl_eff = accept ? ctl : '0;

  // row of cells, each wired to its neighbors; the ends feed back on themselves
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ilir_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SEL_W       (SEL_W),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl_eff),
      .sel        (sel),
      .new_value  (new_value),
      .from_left  (cell_value[(i == 0) ? i : i - 1]),
      .from_right (cell_value[(i == CAPACITY - 1) ? i : i + 1]),
      .value      (cell_value[i])
    );
  end

  // read select: and-or over the row, one term per cell
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_sel == SEL_W'(i)) begin
        rd_data = rd_data | cell_value[i];
      end
    end
  end

  assign rd_wide = ilir_pkg::MAX_VALUE_W'(rd_data);

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value  <= rd_hit ? rd_wide[ilir_pkg::DATA_W-1:0] : '0;
      rsp.value_valid <= rd_hit;
      rsp.entry_count <= ilir_pkg::COUNT_W'(count_next);
      rsp.status      <= status_next;
    end
  end

endmodule

>>> sv/ilir_cell.sv
module ilir_cell #(
  parameter int VALUE_WIDTH = ilir_pkg::VALUE_WIDTH_DEF,
  parameter int SEL_W       = ilir_pkg::POS_W,
  parameter int CELL_INDEX  = 0
) (
  input  logic                   clk,
  input  ilir_pkg::cell_ctl_t    ctl,
  input  logic [SEL_W-1:0]       sel,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [VALUE_WIDTH-1:0] from_left,
  input  logic [VALUE_WIDTH-1:0] from_right,
  output logic [VALUE_WIDTH-1:0] value
);

  localparam logic [SEL_W-1:0] MY_INDEX = SEL_W'(CELL_INDEX);

  logic [VALUE_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    if (ctl.wr_at && (sel == MY_INDEX)) begin
      value_next = new_value;
    end else if (ctl.shift_up && (MY_INDEX > sel)) begin
      value_next = from_left;
    end else if (ctl.shift_down && (MY_INDEX >= sel)) begin
      value_next = from_right;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> dv/tb_indexed_list_insert_remove.sv
module tb_indexed_list_insert_remove;
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  localparam int LIST_DEPTH      = CAPACITY_DEF;
  localparam int ITEMS_PER_PHASE = 580;
  // margin after the last result, to catch stray results
  localparam int DRAIN_CYCLES    = 4;
  // 3-bit command code that the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  // one command transaction as it goes onto the request channel
  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;
  } list_cmd_t;

  // one result transaction as the block should return it
  typedef struct {
    logic [DATA_W-1:0]   read_value;
    logic                value_valid;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
  } list_reply_t;

  // flavor of a random episode: how hard it pushes the list toward full or empty
  typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} list_mix_t;

  logic clk;
  logic rst;

  ilir_req_if req_ch ();
  ilir_rsp_if rsp_ch ();

  indexed_list_insert_remove i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // commands waiting to be driven, and results predicted but not yet seen
  list_cmd_t   command_backlog[$];
  list_reply_t predicted_replies[$];

  // shadow copy of the list, advanced once per accepted command
  logic [DATA_W-1:0] mirror_slots [LIST_DEPTH];
  int                mirror_count;

  // entry count as the stimulus generator expects it once its backlog is consumed
  int planned_count;

  int items_queued;
  int items_accepted;
  int replies_checked;
  int error_count;
  int full_hits;
  int bad_index_hits;
  int read_hits;
  int peak_count;
  int cmd_tally [8];

  int source_idle_pct;
  int sink_stall_pct;

  // set at the rising edge when the request transaction went through
  bit        req_taken;
  list_cmd_t next_cmd;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // reset held from the start, released on a falling edge
  initial begin
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_APPEND;
    req_ch.position     = '0;
    req_ch.item_value   = '0;
    rsp_ch.ready        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("indexed_list_insert_remove regression: fail");
    $finish;
  end

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] mismatch on result %0d: %s", $realtime, replies_checked, what);
  endtask

  // predictor: advances the shadow list by one command and returns the result
  function automatic list_reply_t apply_list_command(list_cmd_t c);
    list_reply_t r;
    int p;
    r.read_value  = '0;
    r.value_valid = 1'b0;
    r.status      = ST_OK;
    p = int'(c.position);
    case (c.command)
      CMD_APPEND: begin
        if (mirror_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_slots[mirror_count] = c.item_value;
          mirror_count++;
        end
      end
      CMD_INSERT: begin
        // index check wins over the full check
        if (p > mirror_count) begin
          r.status = ST_BAD_INDEX;
        end else if (mirror_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = mirror_count; i > p; i--) mirror_slots[i] = mirror_slots[i-1];
          mirror_slots[p] = c.item_value;
          mirror_count++;
        end
      end
      CMD_REMOVE: begin
        if (p >= mirror_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = p; i + 1 < mirror_count; i++) mirror_slots[i] = mirror_slots[i+1];
          mirror_count--;
        end
      end
      CMD_OVERWRITE: begin
        if (p >= mirror_count) r.status = ST_BAD_INDEX;
        else mirror_slots[p] = c.item_value;
      end
      CMD_READ: begin
        if (p < mirror_count) begin
          r.read_value  = mirror_slots[p];
          r.value_valid = 1'b1;
        end
      end
      CMD_READ_LAST: begin
        if (mirror_count > 0) begin
          r.read_value  = mirror_slots[mirror_count-1];
          r.value_valid = 1'b1;
        end
      end
      CMD_CLEAR: begin
        mirror_count = 0;
      end
      default: begin
        // unused code leaves everything alone
      end
    endcase
    r.entry_count = COUNT_W'(mirror_count);
    return r;
  endfunction

  // push a command and keep the planned count in step so later positions make sense
  function automatic void queue_command(logic [CMD_W-1:0] command,
                                        logic [POS_W-1:0] position,
                                        logic [DATA_W-1:0] item_value);
    list_cmd_t c;
    int p;
    c.command    = command;
    c.position   = position;
    c.item_value = item_value;
    command_backlog.push_back(c);
    items_queued++;
    p = int'(position);
    case (command)
      CMD_APPEND:    if (planned_count < LIST_DEPTH) planned_count++;
      CMD_INSERT:    if (p <= planned_count && planned_count < LIST_DEPTH) planned_count++;
      CMD_REMOVE:    if (p < planned_count) planned_count--;
      CMD_CLEAR:     planned_count = 0;
      default:       ;
    endcase
  endfunction

  // mostly a live index below limit, now and then one at or past it (up to the field max)
  function automatic logic [POS_W-1:0] pick_position(int limit);
    if (limit > 0 && $urandom_range(0, 9) != 0) return POS_W'($urandom_range(0, limit - 1));
    return POS_W'($urandom_range(limit, (1 << POS_W) - 1));
  endfunction

  function automatic void queue_random_command(list_mix_t mix);
    int roll;
    int grow_pct;
    int shrink_pct;
    logic [DATA_W-1:0] v;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 15))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    grow_pct   = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 15 : 35;
    shrink_pct = (mix == MIX_GROW) ? 8  : (mix == MIX_SHRINK) ? 55 : 25;
    if (roll < 2) begin
      queue_command(CMD_CLEAR, POS_W'($urandom), v);
    end else if (roll < 4) begin
      queue_command(CMD_UNUSED, POS_W'($urandom), v);
    end else if (roll < 4 + grow_pct) begin
      if ($urandom_range(0, 1) == 0) queue_command(CMD_APPEND, POS_W'($urandom), v);
      else queue_command(CMD_INSERT, pick_position(planned_count + 1), v);
    end else if (roll < 4 + grow_pct + shrink_pct) begin
      queue_command(CMD_REMOVE, pick_position(planned_count), v);
    end else begin
      case ($urandom_range(0, 2))
        0:       queue_command(CMD_OVERWRITE, pick_position(planned_count), v);
        1:       queue_command(CMD_READ, pick_position(planned_count), v);
        default: queue_command(CMD_READ_LAST, POS_W'($urandom), v);
      endcase
    end
  endfunction

  // returns once every queued command went through and every result came back
  task automatic wait_until_drained();
    do @(negedge clk);
    while (items_accepted != items_queued || predicted_replies.size() != 0);
  endtask

  // request driver: holds a transaction until it is taken, then may idle at random before the next
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (command_backlog.size() != 0 && $urandom_range(0, 99) >= source_idle_pct) begin
        next_cmd = command_backlog.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.command    <= next_cmd.command;
        req_ch.position   <= next_cmd.position;
        req_ch.item_value <= next_cmd.item_value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // monitor: checks the result side first, since a result never belongs to a
  // command taken at the same edge, then predicts the command just accepted
  always @(posedge clk) begin : sample_bus
    list_reply_t want;
    list_cmd_t   seen;
    list_reply_t reply;
    req_taken = 1'b0;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("result transaction with no command outstanding");
        end else begin
          want = predicted_replies.pop_front();
          if (rsp_ch.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      rsp_ch.read_value, want.read_value));
          if (rsp_ch.value_valid !== want.value_valid)
            report_mismatch($sformatf("value_valid %b, expected %b",
                                      rsp_ch.value_valid, want.value_valid));
          if (rsp_ch.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      rsp_ch.entry_count, want.entry_count));
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_ch.status, want.status));
          replies_checked++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        req_taken       = 1'b1;
        seen.command    = req_ch.command;
        seen.position   = req_ch.position;
        seen.item_value = req_ch.item_value;
        reply = apply_list_command(seen);
        predicted_replies.push_back(reply);
        items_accepted++;
        cmd_tally[seen.command]++;
        if (reply.status == ST_FULL) full_hits++;
        if (reply.status == ST_BAD_INDEX) bad_index_hits++;
        if (reply.value_valid) read_hits++;
        if (mirror_count > peak_count) peak_count = mirror_count;
      end
    end
  end

  initial begin : stimulus
    int produced;
    int span;
    list_mix_t mix;
    source_idle_pct = 26;
    sink_stall_pct  = 50;
    wait (!rst);
    @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      // idling pattern: sender light / receiver heavy, then swapped, then none
      case (phase)
        0: begin
          source_idle_pct = 26;
          sink_stall_pct  = 50;
        end
        1: begin
          source_idle_pct = 50;
          sink_stall_pct  = 26;
        end
        default: begin
          source_idle_pct = 0;
          sink_stall_pct  = 0;
        end
      endcase
      if (phase == 0) begin
        // empty list: reads miss, remove and overwrite and insert past the end fail
        queue_command(CMD_READ,      7'd0,  32'h0000_0001);
        queue_command(CMD_READ_LAST, 7'd0,  32'h0000_0002);
        queue_command(CMD_REMOVE,    7'd0,  32'h0000_0003);
        queue_command(CMD_OVERWRITE, 7'd0,  32'h0000_0004);
        queue_command(CMD_INSERT,    7'd1,  32'h0000_0005);
        queue_command(CMD_INSERT,    7'd64, 32'h0000_0006);
        // build a short list: insert at front, append, insert at end, insert in middle
        queue_command(CMD_INSERT,    7'd0,  32'hFFFF_FFFF);
        queue_command(CMD_APPEND,    7'd0,  32'h0000_0000);
        queue_command(CMD_INSERT,    7'd2,  32'h5A5A_A5A5);
        queue_command(CMD_INSERT,    7'd1,  32'h1234_5678);
        // reads across the list and past its end, up to the largest index field
        queue_command(CMD_READ,      7'd0,   32'h0);
        queue_command(CMD_READ,      7'd1,   32'h0);
        queue_command(CMD_READ,      7'd3,   32'h0);
        queue_command(CMD_READ,      7'd4,   32'h0);
        queue_command(CMD_READ,      7'd127, 32'h0);
        queue_command(CMD_READ_LAST, 7'd0,   32'h0);
        queue_command(CMD_OVERWRITE, 7'd2,   32'hDEAD_BEEF);
        queue_command(CMD_OVERWRITE, 7'd64,  32'h0BAD_0BAD);
        // remove first, remove last, remove past the end
        queue_command(CMD_REMOVE,    7'd0,  32'h0);
        queue_command(CMD_REMOVE,    7'd2,  32'h0);
        queue_command(CMD_REMOVE,    7'd5,  32'h0);
        queue_command(CMD_READ,      7'd1,  32'h0);
        queue_command(CMD_UNUSED,    7'd127, 32'hFFFF_FFFF);
        queue_command(CMD_CLEAR,     7'd0,  32'h0);
        queue_command(CMD_READ_LAST, 7'd0,  32'h0);
      end
      // random episodes; each phase opens with a long growth run that pushes the list toward full
      produced = 0;
      mix  = MIX_GROW;
      span = 110;
      while (produced < ITEMS_PER_PHASE) begin
        for (int k = 0; k < span && produced < ITEMS_PER_PHASE; k++) begin
          queue_random_command(mix);
          produced++;
        end
        mix  = list_mix_t'($urandom_range(0, 2));
        span = $urandom_range(20, 120);
      end
      // sender stays quiet until every result of this phase is back
      wait_until_drained();
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results over %0d commands (%0d reads hit, peak count %0d)",
             replies_checked, items_accepted, read_hits, peak_count);
    $display("commands by code: %0d %0d %0d %0d %0d %0d %0d %0d; full %0d, bad index %0d",
             cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], cmd_tally[4],
             cmd_tally[5], cmd_tally[6], cmd_tally[7], full_hits, bad_index_hits);
    if (error_count == 0) begin
      $display("indexed_list_insert_remove regression: pass");
    end else begin
      $display("indexed_list_insert_remove regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ilir_pkg.sv
sv/ilir_if.sv
sv/ilir_cell.sv
sv/indexed_list_insert_remove.sv
dv/tb_indexed_list_insert_remove.sv
